// ===== sv/usbcep_pkg.sv =====
`timescale 1ns / 1ps

package usbcep_pkg;

  // sizing
  localparam int EP_COUNT     = 8;
  localparam int HID_COUNT    = 4;
  localparam int DESC_ENTRIES = 16;
  localparam int EP0_PACKET   = 64;

  localparam int EP_W   = (EP_COUNT > 1) ? $clog2(EP_COUNT) : 1;
  localparam int HID_W  = (HID_COUNT > 1) ? $clog2(HID_COUNT) : 1;
  localparam int DESC_W = (DESC_ENTRIES > 1) ? $clog2(DESC_ENTRIES) : 1;
  localparam int LEN_W  = 7;

  // beat widths
  localparam int IN_W   = 104;
  localparam int OUT_W  = 64;
  localparam int ACT_W  = 3;

  // handshake codes
  localparam logic [1:0] HS_ACK   = 2'd0;
  localparam logic [1:0] HS_NAK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  // event codes
  localparam logic [2:0] ACT_SETUP   = 3'd0;
  localparam logic [2:0] ACT_IN      = 3'd1;
  localparam logic [2:0] ACT_OUT     = 3'd2;
  localparam logic [2:0] ACT_BUS_RST = 3'd3;
  localparam logic [2:0] ACT_SUSPEND = 3'd4;
  localparam logic [2:0] ACT_LOAD    = 3'd5;

  // request type kinds (bits 6:5)
  localparam logic [1:0] KIND_STD   = 2'd0;
  localparam logic [1:0] KIND_CLASS = 2'd1;

  // recipients
  localparam logic [4:0] RCP_DEVICE   = 5'd0;
  localparam logic [4:0] RCP_ENDPOINT = 5'd2;

  // standard requests
  localparam logic [7:0] REQ_GET_STATUS  = 8'h00;
  localparam logic [7:0] REQ_CLR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_FEATURE = 8'h03;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE   = 8'h0A;
  localparam logic [7:0] REQ_SET_IFACE   = 8'h0B;

  // HID class requests
  localparam logic [7:0] HID_REPORT_GET   = 8'h01;
  localparam logic [7:0] HID_IDLE_GET     = 8'h02;
  localparam logic [7:0] HID_PROTOCOL_GET = 8'h03;
  localparam logic [7:0] HID_REPORT_SET   = 8'h09;
  localparam logic [7:0] HID_IDLE_SET     = 8'h0A;
  localparam logic [7:0] HID_PROTOCOL_SET = 8'h0B;

  // features
  localparam logic [7:0] FEAT_EP_HALT       = 8'h00;
  localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'h01;

endpackage

// ===== sv/usbcep_ram.sv =====
`timescale 1ns / 1ps

module usbcep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/usb_control_endpoint_handler_core.sv =====
`timescale 1ns / 1ps

// Endpoint-0 control engine for a full-speed USB device. Each event beat
// (setup, IN done, OUT done, bus reset, suspend change, descriptor load)
// yields exactly one result beat with the endpoint-0 arming, the state of
// the touched endpoint, the applied address, any inline reply and the copy
// source of the next IN payload. A GET_DESCRIPTOR setup walks the descriptor
// table RAM one entry at a time, a read state then a compare state per entry,
// and stops at the first valid entry whose key matches or after the last entry.
// One event is worked on at a time; a new event is taken while the previous
// result still waits in the output register.
module usb_control_endpoint_handler_core (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: remote_wakeup_supported
  input  logic                        cfg_we,
  input  logic                        cfg_wdata,
  // event beat
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // endpoint, request_type, request_code, request_value, request_index,
  // request_length, received_length, toggle_matched, suspend_now,
  // table_slot, table_base
  input  logic [usbcep_pkg::IN_W-1:0] s_tdata,
  // action
  input  logic [usbcep_pkg::ACT_W-1:0] s_tuser,
  // result beat
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // ep0_send_length, ep0_send_handshake, ep0_send_toggle,
  // ep0_receive_handshake, ep0_receive_toggle, target_handshake,
  // target_toggle, device_address, reply_bytes, copy_source, copy_valid,
  // enumerated
  output logic [usbcep_pkg::OUT_W-1:0] m_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_RD   = 4'b0100,
    ST_CMP  = 4'b1000
  } state_t;

  localparam int EPC = usbcep_pkg::EP_COUNT;
  localparam int HC  = usbcep_pkg::HID_COUNT;
  localparam int DE  = usbcep_pkg::DESC_ENTRIES;

  state_t state;
  logic   done;   // exec finished (descriptor search resolved)

  // latched event
  logic [usbcep_pkg::IN_W-1:0]  in_q;
  logic [usbcep_pkg::ACT_W-1:0] act_q;

  // device state
  logic        rw_supported;
  logic [2:0]  tx_hs [EPC];    // {toggle, handshake}
  logic [2:0]  rx0;
  logic [7:0]  saved_type;
  logic [7:0]  saved_code;
  logic [15:0] remaining;
  logic [15:0] cur_addr;
  logic        cur_valid;
  logic [6:0]  pend_addr;
  logic [6:0]  bus_addr;
  logic [7:0]  cfg_value;
  logic [1:0]  sleep;
  logic [7:0]  hid_idle [HC];
  logic [7:0]  hid_proto [HC];
  logic [DE-1:0] desc_written;
  logic [usbcep_pkg::LEN_W-1:0] armed;
  logic        enum_flag;

  // descriptor search
  logic [usbcep_pkg::DESC_W-1:0] cnt;
  logic        hit;
  logic [31:0] hit_info;
  logic [63:0] ram_rdata;

  // event fields
  logic [3:0]  f_ep;
  logic [7:0]  f_type;
  logic [7:0]  f_code;
  logic [15:0] f_value;
  logic [15:0] f_index;
  logic [15:0] f_len;
  logic [6:0]  f_rlen;
  logic        f_tm;
  logic        f_sn;
  logic [3:0]  f_slot;
  logic [15:0] f_base;

  assign f_ep    = in_q[3:0];
  assign f_type  = in_q[11:4];
  assign f_code  = in_q[19:12];
  assign f_value = in_q[35:20];
  assign f_index = in_q[51:36];
  assign f_len   = in_q[67:52];
  assign f_rlen  = in_q[74:68];
  assign f_tm    = in_q[75];
  assign f_sn    = in_q[76];
  assign f_slot  = in_q[80:77];
  assign f_base  = in_q[96:81];

  logic is_desc;
  assign is_desc = (act_q == usbcep_pkg::ACT_SETUP) && (f_type[6:5] == usbcep_pkg::KIND_STD)
                   && (f_code == usbcep_pkg::REQ_GET_DESC);

  logic commit;
  assign commit   = (state == ST_EXEC) && done && (!m_tvalid || m_tready);
  assign s_tready = (state == ST_IDLE);

  // descriptor table: {info, key}
  logic ram_we;
  assign ram_we = commit && (act_q == usbcep_pkg::ACT_LOAD) && ({1'b0, f_slot} < 5'(DE));

  usbcep_ram #(
    .WIDTH (64),
    .DEPTH (DE)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f_slot[usbcep_pkg::DESC_W-1:0]),
    .wdata ({f_len, f_base, f_index, f_value}),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // next-state values
  logic [2:0]  tx_n [EPC];
  logic [2:0]  rx0_n;
  logic [15:0] rem_n;
  logic [15:0] cur_addr_n;
  logic        cur_valid_n;
  logic [6:0]  pend_n;
  logic [6:0]  bus_addr_n;
  logic [7:0]  cfg_n;
  logic [1:0]  sleep_n;
  logic [7:0]  idle_n [HC];
  logic [7:0]  proto_n [HC];
  logic [usbcep_pkg::LEN_W-1:0] armed_n;
  logic        enum_n;
  logic [3:0]  target;
  logic [15:0] reply;
  logic [15:0] src;
  logic        cvalid;
  logic [usbcep_pkg::OUT_W-1:0] m_data_n;

  // event processing
  always_comb begin
    logic [1:0]  cap;
    logic        stall;
    logic        desc_done;
    logic        epok;
    logic        hidok;
    logic [3:0]  iep;
    logic [4:0]  recip;
    logic [7:0]  feat;
    logic [15:0] total;
    logic [15:0] len16;
    logic [15:0] n16;
    logic [15:0] got;
    logic [15:0] rem_tmp;
    logic [2:0]  tgt_hs;

    cap       = 2'd0;
    stall     = 1'b0;
    desc_done = 1'b0;
    iep       = f_index[3:0];
    epok      = f_index[7] && ({1'b0, iep} < 5'(EPC));
    hidok     = {1'b0, f_index} < 17'(HC);
    recip     = f_type[4:0];
    feat      = f_value[7:0];
    total     = '0;
    len16     = '0;
    n16       = '0;
    got       = '0;
    rem_tmp   = '0;

    for (int i = 0; i < EPC; i++) tx_n[i] = tx_hs[i];
    for (int i = 0; i < HC; i++) begin
      idle_n[i]  = hid_idle[i];
      proto_n[i] = hid_proto[i];
    end
    rx0_n       = rx0;
    rem_n       = remaining;
    cur_addr_n  = cur_addr;
    cur_valid_n = cur_valid;
    pend_n      = pend_addr;
    bus_addr_n  = bus_addr;
    cfg_n       = cfg_value;
    sleep_n     = sleep;
    armed_n     = armed;
    enum_n      = enum_flag;
    target      = 4'd0;
    reply       = 16'd0;
    src         = 16'd0;
    cvalid      = 1'b0;

    case (act_q)
      usbcep_pkg::ACT_SETUP: begin
        tx_n[0]     = {1'b1, usbcep_pkg::HS_NAK};
        rx0_n       = {1'b1, usbcep_pkg::HS_NAK};
        rem_n       = f_len;
        cur_valid_n = 1'b0;
        if (f_type[6:5] == usbcep_pkg::KIND_CLASS) begin
          case (f_code)
            usbcep_pkg::HID_REPORT_GET, usbcep_pkg::HID_REPORT_SET: ;
            usbcep_pkg::HID_IDLE_SET: begin
              if (hidok) idle_n[f_index[usbcep_pkg::HID_W-1:0]] = f_value[15:8];
            end
            usbcep_pkg::HID_PROTOCOL_SET: begin
              if (hidok) proto_n[f_index[usbcep_pkg::HID_W-1:0]] = feat;
            end
            usbcep_pkg::HID_IDLE_GET: begin
              if (hidok) begin
                reply = {8'd0, hid_idle[f_index[usbcep_pkg::HID_W-1:0]]};
                cap   = 2'd1;
              end
            end
            usbcep_pkg::HID_PROTOCOL_GET: begin
              if (hidok) begin
                reply = {8'd0, hid_proto[f_index[usbcep_pkg::HID_W-1:0]]};
                cap   = 2'd1;
              end
            end
            default: stall = 1'b1;
          endcase
        end else if (f_type[6:5] == usbcep_pkg::KIND_STD) begin
          case (f_code)
            usbcep_pkg::REQ_GET_STATUS: begin
              cap = 2'd2;
              if (recip == usbcep_pkg::RCP_DEVICE) begin
                reply = rw_supported ? {14'd0, sleep[0], 1'b0} : 16'd0;
              end else if (recip == usbcep_pkg::RCP_ENDPOINT && epok) begin
                // endpoint 0 already shows the nak armed by this setup
                target = iep;
                reply  = {15'd0,
                          tx_n[iep[usbcep_pkg::EP_W-1:0]][1:0] == usbcep_pkg::HS_STALL};
              end else begin
                stall = 1'b1;
              end
            end
            usbcep_pkg::REQ_CLR_FEATURE: begin
              if (recip == usbcep_pkg::RCP_DEVICE && rw_supported) begin
                if (feat == usbcep_pkg::FEAT_REMOTE_WAKEUP) sleep_n[0] = 1'b0;
                else stall = 1'b1;
              end else if (recip == usbcep_pkg::RCP_ENDPOINT
                           && feat == usbcep_pkg::FEAT_EP_HALT && epok) begin
                target = iep;
                tx_n[iep[usbcep_pkg::EP_W-1:0]] = {1'b0, usbcep_pkg::HS_NAK};
              end else begin
                stall = 1'b1;
              end
            end
            usbcep_pkg::REQ_SET_FEATURE: begin
              if (recip == usbcep_pkg::RCP_DEVICE) begin
                if (rw_supported && feat == usbcep_pkg::FEAT_REMOTE_WAKEUP) sleep_n[0] = 1'b1;
                else stall = 1'b1;
              end else if (recip == usbcep_pkg::RCP_ENDPOINT
                           && feat == usbcep_pkg::FEAT_EP_HALT) begin
                if (epok) begin
                  target = iep;
                  tx_n[iep[usbcep_pkg::EP_W-1:0]] =
                    {tx_n[iep[usbcep_pkg::EP_W-1:0]][2], usbcep_pkg::HS_STALL};
                end
              end else begin
                stall = 1'b1;
              end
            end
            usbcep_pkg::REQ_SET_ADDRESS: pend_n = feat[6:0];
            usbcep_pkg::REQ_GET_DESC: begin
              if (!hit) begin
                stall = 1'b1;
              end else begin
                desc_done   = 1'b1;
                total       = (f_len < hit_info[31:16]) ? f_len : hit_info[31:16];
                len16       = (total >= 16'(usbcep_pkg::EP0_PACKET))
                              ? 16'(usbcep_pkg::EP0_PACKET) : total;
                src         = hit_info[15:0];
                cvalid      = 1'b1;
                rem_n       = total - len16;
                cur_addr_n  = hit_info[15:0] + len16;
                cur_valid_n = 1'b1;
                armed_n     = len16[usbcep_pkg::LEN_W-1:0];
                tx_n[0]     = {1'b1, usbcep_pkg::HS_ACK};
              end
            end
            usbcep_pkg::REQ_GET_CONFIG: begin
              reply = {8'd0, cfg_value};
              cap   = 2'd1;
            end
            usbcep_pkg::REQ_SET_CONFIG: begin
              cfg_n  = feat;
              enum_n = 1'b1;
            end
            usbcep_pkg::REQ_GET_IFACE: cap = 2'd1;
            usbcep_pkg::REQ_SET_IFACE: ;
            default: stall = 1'b1;
          endcase
        end

        // status / data stage arming
        if (!desc_done) begin
          if (stall) begin
            tx_n[0] = {1'b1, usbcep_pkg::HS_STALL};
            rx0_n   = {1'b1, usbcep_pkg::HS_STALL};
            reply   = 16'd0;
            target  = 4'd0;
          end else if (f_type[7]) begin
            n16     = (f_len < {14'd0, cap}) ? f_len : {14'd0, cap};
            armed_n = n16[usbcep_pkg::LEN_W-1:0];
            rem_n   = 16'd0;
            tx_n[0] = {1'b1, usbcep_pkg::HS_ACK};
          end else if (f_len == 16'd0) begin
            armed_n = '0;
            tx_n[0] = {1'b1, usbcep_pkg::HS_ACK};
          end else begin
            rx0_n = {1'b1, usbcep_pkg::HS_ACK};
          end
        end
      end

      usbcep_pkg::ACT_IN: begin
        if (f_ep != 4'd0) begin
          if ({1'b0, f_ep} < 5'(EPC)) begin
            target = f_ep;
            tx_n[f_ep[usbcep_pkg::EP_W-1:0]] =
              {~tx_hs[f_ep[usbcep_pkg::EP_W-1:0]][2], usbcep_pkg::HS_NAK};
          end
        end else begin
          if (remaining == 16'd0) rx0_n = {1'b1, usbcep_pkg::HS_ACK};
          if (cur_valid) begin
            len16   = (remaining >= 16'(usbcep_pkg::EP0_PACKET))
                      ? 16'(usbcep_pkg::EP0_PACKET) : remaining;
            src     = cur_addr;
            cvalid  = 1'b1;
            rem_tmp = remaining - len16;
            rem_n   = rem_tmp;
            if (rem_tmp != 16'd0) begin
              cur_addr_n = cur_addr + len16;
            end else begin
              cur_valid_n = 1'b0;
              cur_addr_n  = 16'd0;
            end
            armed_n = len16[usbcep_pkg::LEN_W-1:0];
            tx_n[0] = {~tx_hs[0][2], tx_hs[0][1:0]};
          end else if (saved_type[6:5] == usbcep_pkg::KIND_STD
                       && saved_code == usbcep_pkg::REQ_SET_ADDRESS) begin
            bus_addr_n = pend_addr;
          end
        end
      end

      usbcep_pkg::ACT_OUT: begin
        if (f_ep == 4'd0 && f_tm) begin
          got     = ({9'd0, f_rlen} > remaining) ? remaining : {9'd0, f_rlen};
          rem_tmp = remaining - got;
          rem_n   = rem_tmp;
          if (rem_tmp == 16'd0) begin
            armed_n = '0;
            tx_n[0] = {1'b1, usbcep_pkg::HS_ACK};
          end else begin
            rx0_n = {~rx0[2], rx0[1:0]};
          end
        end
      end

      usbcep_pkg::ACT_BUS_RST: begin
        cfg_n      = 8'd0;
        pend_n     = 7'd0;
        bus_addr_n = 7'd0;
        sleep_n    = 2'd0;
        enum_n     = 1'b0;
        for (int i = 0; i < EPC; i++) tx_n[i] = {1'b0, usbcep_pkg::HS_NAK};
        rx0_n = {1'b0, usbcep_pkg::HS_ACK};
      end

      usbcep_pkg::ACT_SUSPEND: sleep_n[1] = f_sn;

      default: ;
    endcase

    tgt_hs = tx_n[target[usbcep_pkg::EP_W-1:0]];
    if (!({1'b0, target} < 5'(EPC))) tgt_hs = tx_n[0];

    m_data_n = {7'd0, enum_n, cvalid, src, reply, bus_addr_n, tgt_hs[2], tgt_hs[1:0],
                rx0_n[2], rx0_n[1:0], tx_n[0][2], tx_n[0][1:0], armed_n};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      hit   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
            done  <= 1'b0;
            hit   <= 1'b0;
            cnt   <= '0;
          end
        end
        ST_EXEC: begin
          if (!done) begin
            if (is_desc) state <= ST_RD;
            else done <= 1'b1;
          end else if (commit) begin
            state <= ST_IDLE;
          end
        end
        ST_RD: state <= ST_CMP;
        ST_CMP: begin
          if (desc_written[cnt] && ram_rdata[31:0] == {f_index, f_value}) begin
            hit   <= 1'b1;
            done  <= 1'b1;
            state <= ST_EXEC;
          end else if (cnt == usbcep_pkg::DESC_W'(DE - 1)) begin
            done  <= 1'b1;
            state <= ST_EXEC;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // matched entry info
  always_ff @(posedge clk) begin
    if (state == ST_CMP) hit_info <= ram_rdata[63:32];
  end

  // event capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q  <= s_tdata;
      act_q <= s_tuser;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) rw_supported <= 1'b0;
    else if (cfg_we) rw_supported <= cfg_wdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) m_tdata <= m_data_n;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EPC; i++) tx_hs[i] <= {1'b0, usbcep_pkg::HS_NAK};
      for (int i = 0; i < HC; i++) begin
        hid_idle[i]  <= 8'd0;
        hid_proto[i] <= 8'd0;
      end
      rx0          <= {1'b0, usbcep_pkg::HS_ACK};
      saved_type   <= 8'd0;
      saved_code   <= 8'd0;
      remaining    <= 16'd0;
      cur_addr     <= 16'd0;
      cur_valid    <= 1'b0;
      pend_addr    <= 7'd0;
      bus_addr     <= 7'd0;
      cfg_value    <= 8'd0;
      sleep        <= 2'd0;
      desc_written <= '0;
      armed        <= '0;
      enum_flag    <= 1'b0;
    end else if (commit) begin
      for (int i = 0; i < EPC; i++) tx_hs[i] <= tx_n[i];
      for (int i = 0; i < HC; i++) begin
        hid_idle[i]  <= idle_n[i];
        hid_proto[i] <= proto_n[i];
      end
      rx0       <= rx0_n;
      remaining <= rem_n;
      cur_addr  <= cur_addr_n;
      cur_valid <= cur_valid_n;
      pend_addr <= pend_n;
      bus_addr  <= bus_addr_n;
      cfg_value <= cfg_n;
      sleep     <= sleep_n;
      armed     <= armed_n;
      enum_flag <= enum_n;
      if (act_q == usbcep_pkg::ACT_SETUP) begin
        saved_type <= f_type;
        saved_code <= f_code;
      end
      if (ram_we) desc_written[f_slot[usbcep_pkg::DESC_W-1:0]] <= 1'b1;
    end
  end

endmodule

// ===== sim/tb_usb_control_endpoint_handler_core.sv =====
`timescale 1ns / 1ps

module tb_usb_control_endpoint_handler_core;
  import usbcep_pkg::*;

  // event fields, highest bits first in tdata
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] table_base;
    logic [3:0]  table_slot;
    logic        suspend_now;
    logic        toggle_matched;
    logic [6:0]  received_length;
    logic [15:0] request_length;
    logic [15:0] request_index;
    logic [15:0] request_value;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
    logic [3:0]  endpoint;
  } event_fields_t;

  typedef struct {
    logic [2:0]    action;
    event_fields_t f;
  } usb_event_t;

  // result fields, highest bits first in tdata
  typedef struct packed {
    logic [6:0]  pad;
    logic        enumerated;
    logic        copy_valid;
    logic [15:0] copy_source;
    logic [15:0] reply_bytes;
    logic [6:0]  device_address;
    logic        target_toggle;
    logic [1:0]  target_handshake;
    logic        ep0_receive_toggle;
    logic [1:0]  ep0_receive_handshake;
    logic        ep0_send_toggle;
    logic [1:0]  ep0_send_handshake;
    logic [6:0]  ep0_send_length;
  } ep0_status_t;

  localparam int STALL_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [ACT_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;

  usb_control_endpoint_handler_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  usb_event_t  event_queue[$];
  ep0_status_t status_queue[$];
  usb_event_t  driven_event;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 0;
  int hold_count = 0;
  int mismatches = 0;
  int watchdog = 0;
  logic [31:0] loaded_keys[DESC_ENTRIES];

  // shadow device state
  logic        wakeup_en;
  logic [1:0]  tx_hs[EP_COUNT];
  logic        tx_tog[EP_COUNT];
  logic [1:0]  rx_hs[EP_COUNT];
  logic        rx_tog[EP_COUNT];
  logic [7:0]  last_type, last_code;
  logic [15:0] bytes_left;
  logic [15:0] cursor;
  logic        cursor_live;
  logic [6:0]  pending_addr, applied_addr;
  logic [7:0]  config_value;
  logic [1:0]  sleep_bits;
  logic [7:0]  idle_rate[HID_COUNT];
  logic [7:0]  proto_mode[HID_COUNT];
  logic [31:0] desc_key[DESC_ENTRIES];
  logic [31:0] desc_info[DESC_ENTRIES];
  logic        desc_valid[DESC_ENTRIES];
  logic [6:0]  armed_len;
  logic        enum_flag;

  function automatic void reset_endpoints();
    for (int i = 0; i < EP_COUNT; i++) begin
      tx_hs[i] = HS_NAK; tx_tog[i] = 0;
      rx_hs[i] = HS_NAK; rx_tog[i] = 0;
    end
    rx_hs[0] = HS_ACK;
  endfunction

  function automatic void reset_shadow();
    wakeup_en = 0;
    reset_endpoints();
    last_type = 0; last_code = 0; bytes_left = 0; cursor = 0; cursor_live = 0;
    pending_addr = 0; applied_addr = 0; config_value = 0; sleep_bits = 0;
    for (int i = 0; i < HID_COUNT; i++) begin
      idle_rate[i] = 0; proto_mode[i] = 0;
    end
    for (int i = 0; i < DESC_ENTRIES; i++) desc_valid[i] = 0;
    armed_len = 0; enum_flag = 0;
  endfunction

  // handles a setup beat; returns 1 when endpoint 0 stalls
  function automatic bit run_setup(input event_fields_t f, inout int tgt,
                                   inout logic [15:0] reply, inout logic [15:0] src,
                                   inout logic cvalid);
    logic [1:0] kind;
    logic [4:0] recip;
    logic [3:0] ep;
    logic [7:0] feat;
    logic [HID_W-1:0] hix;
    bit epok, hidok, stall;
    int cap, n, len, hit, total;
    kind = f.request_type[6:5];
    recip = f.request_type[4:0];
    ep = f.request_index[3:0];
    feat = f.request_value[7:0];
    hix = f.request_index[HID_W-1:0];
    epok = f.request_index[7] && ep < EP_COUNT;
    hidok = f.request_index < HID_COUNT;
    stall = 0;
    cap = 0;
    tx_hs[0] = HS_NAK; tx_tog[0] = 1;
    rx_hs[0] = HS_NAK; rx_tog[0] = 1;
    last_type = f.request_type;
    last_code = f.request_code;
    bytes_left = f.request_length;
    cursor_live = 0;
    if (kind == KIND_CLASS) begin
      case (f.request_code)
        HID_REPORT_GET, HID_REPORT_SET: ;
        HID_IDLE_SET: if (hidok) idle_rate[hix] = f.request_value[15:8];
        HID_PROTOCOL_SET: if (hidok) proto_mode[hix] = feat;
        HID_IDLE_GET: if (hidok) begin reply = {8'd0, idle_rate[hix]}; cap = 1; end
        HID_PROTOCOL_GET: if (hidok) begin reply = {8'd0, proto_mode[hix]}; cap = 1; end
        default: stall = 1;
      endcase
    end else if (kind == KIND_STD) begin
      case (f.request_code)
        REQ_GET_STATUS: begin
          cap = 2;
          if (recip == RCP_DEVICE) begin
            reply = wakeup_en ? {14'd0, sleep_bits[0], 1'b0} : 16'd0;
          end else if (recip == RCP_ENDPOINT && epok) begin
            tgt = int'(ep);
            reply = (tx_hs[ep[EP_W-1:0]] == HS_STALL) ? 16'd1 : 16'd0;
          end else stall = 1;
        end
        REQ_CLR_FEATURE: begin
          if (recip == RCP_DEVICE && wakeup_en) begin
            if (feat == FEAT_REMOTE_WAKEUP) sleep_bits[0] = 0; else stall = 1;
          end else if (recip == RCP_ENDPOINT && feat == FEAT_EP_HALT && epok) begin
            tgt = int'(ep);
            tx_hs[ep[EP_W-1:0]] = HS_NAK; tx_tog[ep[EP_W-1:0]] = 0;
          end else stall = 1;
        end
        REQ_SET_FEATURE: begin
          if (recip == RCP_DEVICE) begin
            if (wakeup_en && feat == FEAT_REMOTE_WAKEUP) sleep_bits[0] = 1; else stall = 1;
          end else if (recip == RCP_ENDPOINT && feat == FEAT_EP_HALT) begin
            if (epok) begin
              tgt = int'(ep);
              tx_hs[ep[EP_W-1:0]] = HS_STALL;
            end
          end else stall = 1;
        end
        REQ_SET_ADDRESS: pending_addr = feat[6:0];
        REQ_GET_DESC: begin
          hit = -1;
          for (int i = DESC_ENTRIES - 1; i >= 0; i--)
            if (desc_valid[i] && desc_key[i] == {f.request_index, f.request_value}) hit = i;
          if (hit < 0) stall = 1;
          else begin
            total = int'(desc_info[hit][31:16]);
            if (f.request_length < total) total = int'(f.request_length);
            len = total >= EP0_PACKET ? EP0_PACKET : total;
            src = desc_info[hit][15:0];
            cvalid = 1;
            bytes_left = 16'(total - len);
            cursor = 16'(int'(desc_info[hit][15:0]) + len);
            cursor_live = 1;
            armed_len = 7'(len);
            tx_hs[0] = HS_ACK; tx_tog[0] = 1;
            return 0;
          end
        end
        REQ_GET_CONFIG: begin reply = {8'd0, config_value}; cap = 1; end
        REQ_SET_CONFIG: begin config_value = feat; enum_flag = 1; end
        REQ_GET_IFACE: begin reply = 16'd0; cap = 1; end
        REQ_SET_IFACE: ;
        default: stall = 1;
      endcase
    end
    if (stall) begin
      tx_hs[0] = HS_STALL; tx_tog[0] = 1;
      rx_hs[0] = HS_STALL; rx_tog[0] = 1;
      reply = 16'd0;
      tgt = 0;
      return 1;
    end
    if (f.request_type[7]) begin
      n = f.request_length < cap ? int'(f.request_length) : cap;
      armed_len = 7'(n);
      bytes_left = 0;
      tx_hs[0] = HS_ACK; tx_tog[0] = 1;
    end else if (f.request_length == 0) begin
      armed_len = 0;
      tx_hs[0] = HS_ACK; tx_tog[0] = 1;
    end else begin
      rx_hs[0] = HS_ACK; rx_tog[0] = 1;
    end
    return 0;
  endfunction

  // advances the shadow state by one event and returns the status beat it yields
  function automatic ep0_status_t next_status(input usb_event_t ev);
    ep0_status_t r;
    int tgt, len, got;
    logic [15:0] reply, src;
    logic cvalid;
    bit dummy;
    event_fields_t f;
    f = ev.f;
    tgt = 0; reply = 0; src = 0; cvalid = 0;
    case (ev.action)
      ACT_SETUP: dummy = run_setup(f, tgt, reply, src, cvalid);
      ACT_IN: begin
        if (f.endpoint != 0) begin
          if (f.endpoint < EP_COUNT) begin
            tgt = int'(f.endpoint);
            tx_tog[tgt] = ~tx_tog[tgt];
            tx_hs[tgt] = HS_NAK;
          end
        end else begin
          if (bytes_left == 0) begin rx_hs[0] = HS_ACK; rx_tog[0] = 1; end
          if (cursor_live) begin
            len = bytes_left >= EP0_PACKET ? EP0_PACKET : int'(bytes_left);
            src = cursor;
            cvalid = 1;
            bytes_left = 16'(int'(bytes_left) - len);
            if (bytes_left > 0) cursor = 16'(int'(cursor) + len);
            else begin cursor_live = 0; cursor = 0; end
            armed_len = 7'(len);
            tx_tog[0] = ~tx_tog[0];
          end else if (last_type[6:5] == KIND_STD && last_code == REQ_SET_ADDRESS) begin
            applied_addr = pending_addr;
          end
        end
      end
      ACT_OUT: begin
        if (f.endpoint == 0 && f.toggle_matched) begin
          got = int'(f.received_length);
          if (got > bytes_left) got = int'(bytes_left);
          bytes_left = 16'(int'(bytes_left) - got);
          if (bytes_left == 0) begin
            armed_len = 0;
            tx_hs[0] = HS_ACK; tx_tog[0] = 1;
          end else rx_tog[0] = ~rx_tog[0];
        end
      end
      ACT_BUS_RST: begin
        config_value = 0; pending_addr = 0; applied_addr = 0;
        sleep_bits = 0; enum_flag = 0;
        reset_endpoints();
      end
      ACT_SUSPEND: sleep_bits[1] = f.suspend_now;
      ACT_LOAD: begin
        desc_key[f.table_slot] = {f.request_index, f.request_value};
        desc_info[f.table_slot] = {f.request_length, f.table_base};
        desc_valid[f.table_slot] = 1;
      end
      default: ;
    endcase
    if (tgt >= EP_COUNT) tgt = 0;
    r = '0;
    r.ep0_send_length = armed_len;
    r.ep0_send_handshake = tx_hs[0];
    r.ep0_send_toggle = tx_tog[0];
    r.ep0_receive_handshake = rx_hs[0];
    r.ep0_receive_toggle = rx_tog[0];
    r.target_handshake = tx_hs[tgt];
    r.target_toggle = tx_tog[tgt];
    r.device_address = applied_addr;
    r.reply_bytes = reply;
    r.copy_source = src;
    r.copy_valid = cvalid;
    r.enumerated = enum_flag;
    return r;
  endfunction

  // driver: predicts on acceptance, then offers the next pending event
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) status_queue.push_back(next_status(driven_event));
      if (!s_tvalid || s_tready) begin
        if (event_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_event = event_queue.pop_front();
          s_tvalid <= 1;
          s_tdata <= driven_event.f;
          s_tuser <= driven_event.action;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest expectation
  always @(posedge clk) begin
    ep0_status_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (status_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = status_queue.pop_front();
          if (got.ep0_send_length !== want.ep0_send_length ||
              got.ep0_send_handshake !== want.ep0_send_handshake ||
              got.ep0_send_toggle !== want.ep0_send_toggle ||
              got.ep0_receive_handshake !== want.ep0_receive_handshake ||
              got.ep0_receive_toggle !== want.ep0_receive_toggle ||
              got.target_handshake !== want.target_handshake ||
              got.target_toggle !== want.target_toggle ||
              got.device_address !== want.device_address ||
              got.reply_bytes !== want.reply_bytes ||
              got.copy_source !== want.copy_source ||
              got.copy_valid !== want.copy_valid ||
              got.enumerated !== want.enumerated || got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
          end
        end
      end
      // long hold-off, counted here
      if (hold_request && hold_count == 0) begin
        hold_count = 400;
        hold_request = 0;
      end
      if (hold_count > 0) begin
        hold_count--;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on beats moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (!s_tvalid && event_queue.size() == 0 && status_queue.size() == 0))
        watchdog <= 0;
      else
        watchdog <= watchdog + 1;
      if (watchdog >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic usb_event_t make_event(input logic [2:0] act);
    usb_event_t ev;
    ev.action = act;
    ev.f = IN_W'({$urandom, $urandom, $urandom, $urandom});
    ev.f.pad = '0;
    ev.f.received_length = 7'($urandom_range(64));
    return ev;
  endfunction

  function automatic usb_event_t setup_event(input logic [7:0] typ, input logic [7:0] code,
                                             input logic [15:0] val, input logic [15:0] idx,
                                             input logic [15:0] wlen);
    usb_event_t ev;
    ev = make_event(ACT_SETUP);
    ev.f.request_type = typ;
    ev.f.request_code = code;
    ev.f.request_value = val;
    ev.f.request_index = idx;
    ev.f.request_length = wlen;
    return ev;
  endfunction

  function automatic usb_event_t done_event(input logic [2:0] act, input logic [3:0] ep);
    usb_event_t ev;
    ev = make_event(act);
    ev.f.endpoint = ep;
    ev.f.toggle_matched = ($urandom_range(9) != 0);
    return ev;
  endfunction

  function automatic usb_event_t load_event(input logic [3:0] slot, input logic [31:0] key,
                                            input logic [15:0] len, input logic [15:0] base);
    usb_event_t ev;
    ev = make_event(ACT_LOAD);
    ev.f.table_slot = slot;
    {ev.f.request_index, ev.f.request_value} = key;
    ev.f.request_length = len;
    ev.f.table_base = base;
    loaded_keys[slot] = key;
    return ev;
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'($urandom_range(2));
      2: return 16'($urandom_range(300));
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one control transfer with random content, or a stray event
  task automatic queue_random();
    logic [7:0] typ, code;
    logic [15:0] val, idx;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      case ($urandom_range(10))
        0: typ = 8'h00; 1: typ = 8'h80; 2: typ = 8'h02; 3: typ = 8'h82;
        4: typ = 8'h01; 5: typ = 8'h81; 6: typ = 8'h21; 7: typ = 8'hA1;
        8: typ = 8'h40; 9: typ = 8'hC0;
        default: typ = 8'($urandom);
      endcase
      case ($urandom_range(12))
        0: code = REQ_GET_STATUS; 1: code = REQ_CLR_FEATURE; 2: code = REQ_SET_FEATURE;
        3: code = REQ_SET_ADDRESS; 4: code = REQ_GET_DESC; 5: code = REQ_GET_CONFIG;
        6: code = REQ_SET_CONFIG; 7: code = REQ_GET_IFACE; 8: code = REQ_SET_IFACE;
        9: code = HID_PROTOCOL_GET; 10: code = HID_IDLE_GET;
        default: code = 8'($urandom);
      endcase
      val = 16'($urandom);
      if ($urandom_range(2) != 0) val[7:0] = 8'($urandom_range(1));
      case ($urandom_range(3))
        0: idx = {8'h00, 1'b1, 3'b000, 4'($urandom)};
        1: idx = 16'($urandom_range(5));
        default: idx = 16'($urandom);
      endcase
      if (code == REQ_GET_DESC && $urandom_range(9) < 7) begin
        typ = 8'h80;
        {idx, val} = loaded_keys[$urandom_range(DESC_ENTRIES - 1)];
      end
      event_queue.push_back(setup_event(typ, code, val, idx, pick_length()));
      repeat ($urandom_range(4))
        event_queue.push_back(done_event($urandom_range(1) ? ACT_IN : ACT_OUT,
                                         ($urandom_range(7) == 0) ? 4'($urandom) : 4'd0));
    end else if (pick < 85) begin
      event_queue.push_back(done_event(ACT_IN, 4'($urandom)));
    end else if (pick < 89) begin
      event_queue.push_back(make_event(ACT_SUSPEND));
    end else if (pick < 94) begin
      event_queue.push_back(load_event(4'($urandom), $urandom_range(1) ?
                            {16'd0, 8'($urandom_range(3)), 8'($urandom_range(3))} : $urandom,
                            pick_length(), 16'($urandom)));
    end else if (pick < 97) begin
      event_queue.push_back(make_event(ACT_BUS_RST));
    end else begin
      event_queue.push_back(make_event($urandom_range(1) ? 3'd6 : 3'd7));
    end
  endtask

  task automatic wait_drained();
    while (event_queue.size() > 0 || s_tvalid || status_queue.size() > 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_wakeup(input logic v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    wakeup_en = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int sends[5] = '{0, 51, 0, 6, 0};
    int stalls[5] = '{0, 0, 51, 6, 0};
    logic cfgs[5] = '{0, 1, 0, 1, 1};
    reset_shadow();
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: fill the whole descriptor table first
    for (int i = 0; i < DESC_ENTRIES; i++)
      event_queue.push_back(load_event(4'(i), {16'h0000, 8'(i), 8'h02},
                            (i == 0) ? 16'd0 : (i == 1) ? 16'd1 : (i == 2) ? 16'd64 :
                            (i == 3) ? 16'd65 : (i == 4) ? 16'hFFFF : 16'($urandom_range(200)),
                            (i == 4) ? 16'hFFC0 : 16'($urandom)));
    // long descriptor chunks across the address wrap
    event_queue.push_back(setup_event(8'h80, REQ_GET_DESC, 16'h0402, 16'h0000, 16'hFFFF));
    repeat (3) event_queue.push_back(done_event(ACT_IN, 4'd0));
    // missing descriptor, unknown request, vendor request
    event_queue.push_back(setup_event(8'h80, REQ_GET_DESC, 16'h0003, 16'hFFFF, 16'd18));
    event_queue.push_back(setup_event(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'd0));
    event_queue.push_back(setup_event(8'hC0, 8'h55, 16'h0000, 16'h0000, 16'd8));
    // address applied on the status stage
    event_queue.push_back(setup_event(8'h00, REQ_SET_ADDRESS, 16'h00FF, 16'h0000, 16'd0));
    event_queue.push_back(done_event(ACT_IN, 4'd0));
    // endpoint halt set and status, clear on a missing endpoint; HID index out of range; OUT data
    event_queue.push_back(setup_event(8'h02, REQ_SET_FEATURE, 16'h0000, 16'h0087, 16'd0));
    event_queue.push_back(setup_event(8'h82, REQ_GET_STATUS, 16'h0000, 16'h0087, 16'd2));
    event_queue.push_back(setup_event(8'h02, REQ_CLR_FEATURE, 16'h0000, 16'h008F, 16'd0));
    event_queue.push_back(setup_event(8'hA1, HID_IDLE_GET, 16'h0000, 16'h0004, 16'd1));
    event_queue.push_back(setup_event(8'h21, 8'h00, 16'h0000, 16'h0000, 16'd64));
    event_queue.push_back(setup_event(8'h21, HID_REPORT_SET, 16'h0000, 16'h0000, 16'd100));
    event_queue.push_back(done_event(ACT_OUT, 4'd0));
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_wakeup(cfgs[p]);
      send_idle_pct = sends[p];
      recv_stall_pct = stalls[p];
      if (p == 2) hold_request = 1;
      if (p == 0 || p == 4) begin
        event_queue.push_back(setup_event(8'h00, REQ_SET_FEATURE, 16'h0001, 16'h0000, 16'd0));
        event_queue.push_back(setup_event(8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'd2));
        event_queue.push_back(setup_event(8'h00, REQ_CLR_FEATURE, 16'h0001, 16'h0000, 16'd0));
      end
      while (event_queue.size() < 260) queue_random();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/usbcep_pkg.sv
sv/usbcep_ram.sv
sv/usb_control_endpoint_handler_core.sv
sim/tb_usb_control_endpoint_handler_core.sv
